@@ rtl/c_style_integer_parser_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the integer parser
// Short forms for clocked checks with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef C_STYLE_INTEGER_PARSER_MACROS_SVH
`define C_STYLE_INTEGER_PARSER_MACROS_SVH

// Check the consequent in the same cycle as the antecedent
`define CIP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cip: same-cycle check failed");

// Check the consequent in the cycle after the antecedent
`define CIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cip: next-cycle check failed");

`endif

@@ rtl/cip_pkg.sv @@
// ----------------------------------------------------------------------------
// cip_pkg
// Shared types and constants of the C-style integer parser.
// ----------------------------------------------------------------------------
package cip_pkg;

    // Depth of the queue between the classifier and the parser
    localparam int QUEUE_DEPTH = 4;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 64;
    localparam int DIGIT_W = 4;

    // Radix codes as reported on the result
    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_HEX = 2'd1,
        RX_BIN = 2'd2,
        RX_OCT = 2'd3
    } t_radix;

    // Parse phase, one-hot
    typedef enum logic [2:0] {
        PH_SIGN = 3'b001,
        PH_ZERO = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

    // Classified character, as queued for the parser
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;     // symbol value of a hex symbol
        logic               digit_ok;  // byte is 0-9, a-f or A-F
        logic               is_zero;
        logic               is_plus;
        logic               is_minus;
        logic               is_x;      // 'x' or 'X'
        logic               is_b;      // 'b' or 'B'
        logic               sign_en;   // signed mode at acceptance
        logic               last;
    } t_cls;

endpackage

@@ rtl/cip_front.sv @@
// ----------------------------------------------------------------------------
// cip_front
// Accepts characters, holds the mode register and classifies each byte.
// ----------------------------------------------------------------------------
module cip_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [cip_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                        i_last_char,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data,
    input  logic                        i_q_full,
    output logic                        o_push,
    output cip_pkg::t_cls               o_cls
);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] LETTER_OFS = 8'd10;

    logic       r_signed_mode;
    logic       is_dec;
    logic       is_lo;
    logic       is_up;
    logic [7:0] sym;

    // Mode register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b1;
        end else if (i_cfg_valid) begin
            r_signed_mode <= i_cfg_data;
        end
    end

    // Hold off the sender while the queue is full
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Classify the byte
    assign is_dec = (i_char_code >= CH_0)  && (i_char_code <= CH_9);
    assign is_lo  = (i_char_code >= CH_LA) && (i_char_code <= CH_LF);
    assign is_up  = (i_char_code >= CH_UA) && (i_char_code <= CH_UF);

    always_comb begin
        priority if (is_dec) begin
            sym = i_char_code - CH_0;
        end else if (is_lo) begin
            sym = i_char_code - CH_LA + LETTER_OFS;
        end else if (is_up) begin
            sym = i_char_code - CH_UA + LETTER_OFS;
        end else begin
            sym = '0;
        end
    end

    always_comb begin
        o_cls.digit    = sym[cip_pkg::DIGIT_W-1:0];
        o_cls.digit_ok = is_dec || is_lo || is_up;
        o_cls.is_zero  = (i_char_code == CH_0);
        o_cls.is_plus  = (i_char_code == CH_PLUS);
        o_cls.is_minus = (i_char_code == CH_MINUS);
        o_cls.is_x     = (i_char_code == CH_LX) || (i_char_code == CH_UX);
        o_cls.is_b     = (i_char_code == CH_LB) || (i_char_code == CH_UB);
        o_cls.sign_en  = r_signed_mode;
        o_cls.last     = i_last_char;
    end

endmodule

@@ rtl/cip_queue.sv @@
// ----------------------------------------------------------------------------
// cip_queue
// Short FIFO of classified characters between classifier and parser.
// ----------------------------------------------------------------------------
module cip_queue #(
    parameter int DEPTH = cip_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cip_pkg::t_cls i_data,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output cip_pkg::t_cls o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cip_pkg::t_cls    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_FULL);
    assign o_data  = r_mem[r_rd_ptr];

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Advance the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

@@ rtl/cip_back.sv @@
// ----------------------------------------------------------------------------
// cip_back
// Runs the sign, prefix and digit phases and holds the result register.
// ----------------------------------------------------------------------------
module cip_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  cip_pkg::t_cls                i_cls,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [cip_pkg::VALUE_W-1:0]  o_value_bits,
    output logic                         o_well_formed,
    output logic [1:0]                   o_radix_code
);

    localparam int VW = cip_pkg::VALUE_W;
    localparam int DW = cip_pkg::DIGIT_W;

    cip_pkg::t_phase r_phase, n_phase;
    cip_pkg::t_radix r_radix, n_radix, use_radix, fin_radix;
    logic            r_par, n_par;
    logic            r_bad, n_bad;
    logic            r_seen, n_seen;
    logic [VW-1:0]   r_acc, n_acc, acc_shift, acc_step, fin_acc;
    logic            take;
    logic            in_range;
    logic            fin_zero;
    logic            fin_ok;

    logic            r_out_valid;
    logic [VW-1:0]   r_out_val;
    logic            r_out_neg;
    logic            r_out_ok;
    cip_pkg::t_radix r_out_radix;

    // Take a beat unless it ends a token and the result slot stays occupied
    assign o_pop = i_q_valid && (!i_cls.last || !r_out_valid || !i_out_stall);

    // Phase logic for one character
    always_comb begin
        n_phase   = r_phase;
        n_par     = r_par;
        n_radix   = r_radix;
        n_bad     = r_bad;
        n_seen    = r_seen;
        n_acc     = r_acc;
        use_radix = r_radix;
        take      = 1'b0;
        unique case (r_phase)
            cip_pkg::PH_SIGN: begin
                if (i_cls.sign_en && (i_cls.is_plus || i_cls.is_minus)) begin
                    n_par = r_par ^ i_cls.is_minus;
                end else if (i_cls.is_zero) begin
                    n_phase = cip_pkg::PH_ZERO;
                end else begin
                    n_radix   = cip_pkg::RX_DEC;
                    use_radix = cip_pkg::RX_DEC;
                    take      = 1'b1;
                    n_phase   = cip_pkg::PH_BODY;
                end
            end
            cip_pkg::PH_ZERO: begin
                if (i_cls.is_x) begin
                    n_radix = cip_pkg::RX_HEX;
                end else if (i_cls.is_b) begin
                    n_radix = cip_pkg::RX_BIN;
                end else begin
                    n_radix   = cip_pkg::RX_OCT;
                    use_radix = cip_pkg::RX_OCT;
                    take      = 1'b1;
                end
                n_phase = cip_pkg::PH_BODY;
            end
            default: begin
                take = 1'b1;
            end
        endcase

        if (take) begin
            if (i_cls.digit_ok && in_range) begin
                n_acc  = acc_step;
                n_seen = 1'b1;
            end else begin
                n_bad = 1'b1;
            end
        end
    end

    // Digit range check and shift-add by the radix
    always_comb begin
        unique case (use_radix)
            cip_pkg::RX_DEC: begin
                in_range  = ({1'b0, i_cls.digit} < 5'd10);
                acc_shift = (r_acc << 3) + (r_acc << 1);
            end
            cip_pkg::RX_HEX: begin
                in_range  = 1'b1;
                acc_shift = r_acc << 4;
            end
            cip_pkg::RX_BIN: begin
                in_range  = ({1'b0, i_cls.digit} < 5'd2);
                acc_shift = r_acc << 1;
            end
            default: begin
                in_range  = ({1'b0, i_cls.digit} < 5'd8);
                acc_shift = r_acc << 3;
            end
        endcase
        acc_step = acc_shift + {{(VW-DW){1'b0}}, i_cls.digit};
    end

    // Resolve a lone leading zero at the end of the token
    assign fin_zero  = (n_phase == cip_pkg::PH_ZERO);
    assign fin_radix = fin_zero ? cip_pkg::RX_DEC : n_radix;
    assign fin_acc   = fin_zero ? '0 : n_acc;
    assign fin_ok    = (fin_zero || n_seen) && !n_bad;

    // Parse state: advance per beat, clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cip_pkg::PH_SIGN;
            r_par   <= 1'b0;
            r_acc   <= '0;
            r_radix <= cip_pkg::RX_DEC;
            r_bad   <= 1'b0;
            r_seen  <= 1'b0;
        end else if (o_pop) begin
            if (i_cls.last) begin
                r_phase <= cip_pkg::PH_SIGN;
                r_par   <= 1'b0;
                r_acc   <= '0;
                r_radix <= cip_pkg::RX_DEC;
                r_bad   <= 1'b0;
                r_seen  <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_par   <= n_par;
                r_acc   <= n_acc;
                r_radix <= n_radix;
                r_bad   <= n_bad;
                r_seen  <= n_seen;
            end
        end
    end

    // Result register: load on the last beat, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_cls.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cls.last) begin
            r_out_val   <= fin_ok ? fin_acc : '0;
            r_out_neg   <= fin_ok && n_par;
            r_out_ok    <= fin_ok;
            r_out_radix <= fin_radix;
        end
    end

    // Apply the sign on the way out
    assign o_out_valid   = r_out_valid;
    assign o_value_bits  = r_out_neg ? (VW'(0) - r_out_val) : r_out_val;
    assign o_well_formed = r_out_ok;
    assign o_radix_code  = r_out_radix;

endmodule

@@ rtl/c_style_integer_parser.sv @@
// ----------------------------------------------------------------------------
// c_style_integer_parser
// Parses a C-style integer token, one byte per beat, into a 64-bit value.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with i_char_code and i_last_char.
//   A byte is taken at an edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall with o_value_bits, o_well_formed
//   and o_radix_code; one result per byte marked last.
// Config channel: i_cfg_valid / o_cfg_ready, i_cfg_data is signed_mode.
// Throughput: one byte per cycle while o_in_stall is low, set by the
//   combinational shift-add of the accumulator in the parser.
// Result path: a last byte is queued, then popped into the result register.
// A four-entry queue separates the classifier from the parser; while the
//   receiver stalls, the held result stays put, bytes keep flowing until a
//   further last byte reaches the parser, and o_in_stall rises when the
//   queue fills.
// Reset clears the queue, the parse state and the result, and sets
//   signed_mode to 1. No clearing pass is needed.
// ----------------------------------------------------------------------------
module c_style_integer_parser #(
    parameter int QUEUE_DEPTH = cip_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [cip_pkg::CHAR_W-1:0]   i_char_code,
    input  logic                         i_last_char,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [cip_pkg::VALUE_W-1:0]  o_value_bits,
    output logic                         o_well_formed,
    output logic [1:0]                   o_radix_code,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_data
);

    logic          push;
    logic          pop;
    logic          q_valid;
    logic          q_full;
    cip_pkg::t_cls cls_in;
    cip_pkg::t_cls cls_out;

    // Classify incoming bytes
    cip_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cls       (cls_in)
    );

    // Decouple the two halves
    cip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_in),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (cls_out)
    );

    // Parse and report
    cip_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_cls         (cls_out),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_value_bits  (o_value_bits),
        .o_well_formed (o_well_formed),
        .o_radix_code  (o_radix_code)
    );

endmodule

@@ rtl/cip_checker.sv @@
// ----------------------------------------------------------------------------
// cip_checker
// Port-level checks on the integer parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "c_style_integer_parser_macros.svh"

module cip_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [cip_pkg::VALUE_W-1:0]  o_value_bits,
    input logic                         o_well_formed,
    input logic [1:0]                   o_radix_code
);

    logic                           out_held;
    logic [cip_pkg::VALUE_W+2:0]    out_payload;

    assign out_held    = o_out_valid && i_out_stall;
    assign out_payload = {o_value_bits, o_well_formed, o_radix_code};

    // A stalled result beat stays valid
    `CIP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid)

    // A stalled result beat keeps its payload
    `CIP_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_held, $stable(out_payload))

    // A malformed token reports a zero value
    `CIP_ASSERT_SAME(a_bad_zero, i_clk, i_rst_n, o_out_valid && !o_well_formed, o_value_bits == '0)

    // The queue only fills after a byte has been taken
    `CIP_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, $rose(o_in_stall), $past(i_in_valid))

endmodule

bind c_style_integer_parser cip_checker u_cip_checker (.*);
